// ===== sv/iprd_pkg.sv =====
`default_nettype none

package iprd_pkg;

   // Field widths fixed by the item layout.
   localparam int PORT_W  = 16;
   localparam int HID_W   = 8;
   localparam int WORD_W  = 32;
   localparam int SIZE_W  = 4;
   localparam int STAT_W  = 3;

   // Item function codes.
   typedef enum logic [1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_DECODE   = 2'd1,
      FUNC_COMPLETE = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_UNMAPPED = 3'd1,
      ST_STRING   = 3'd2,
      ST_OVERLAP  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // One stored port range.
   typedef struct packed {
      logic [PORT_W-1:0] first;
      logic [PORT_W-1:0] last;
      logic              passthrough;
      logic [HID_W-1:0]  handler;
   } entry_type;

   // One result beat.
   typedef struct packed {
      status_type        status;
      logic [HID_W-1:0]  hit_handler;
      logic              hit_passthrough;
      logic [PORT_W-1:0] port_number;
      logic [SIZE_W-1:0] access_size;
      logic              is_read;
      logic              eax_valid;
      logic [WORD_W-1:0] new_eax;
      logic [WORD_W-1:0] out_value;
      logic              advance_ip;
   } result_type;

   // Mask covering the low size bytes of the accumulator.
   function automatic logic [WORD_W-1:0] low_bytes_mask(input logic [SIZE_W-1:0] size);
      logic [WORD_W-1:0] mask;
      case (size)
         4'd1:    mask = 32'h0000_00FF;
         4'd2:    mask = 32'h0000_FFFF;
         4'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

// ===== sv/iprd_table.sv =====
`default_nettype none

// Range table storage: one write port and one registered read port.
module iprd_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire iprd_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output iprd_pkg::entry_type      rd_data
);

   iprd_pkg::entry_type mem_ff [DEPTH];
   iprd_pkg::entry_type rd_data_ff;

   // Write side.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read side, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/iprd_ctrl.sv =====
`default_nettype none

// Sequencer that, for adds and plain decodes, walks the range table one entry per
// cycle through a single shared range comparator, then forms the result beat.
module iprd_ctrl #(
   parameter int MAX_RANGES = 16,
   parameter int AW         = 4,
   parameter int CW         = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              item_valid,
   output logic                                   item_stall,
   input  wire logic [1:0]                        item_func,
   input  wire logic [iprd_pkg::PORT_W-1:0]       item_range_start,
   input  wire logic [iprd_pkg::PORT_W-1:0]       item_range_end,
   input  wire logic                              item_range_passthrough,
   input  wire logic [iprd_pkg::HID_W-1:0]        item_handler_id,
   input  wire logic [iprd_pkg::WORD_W-1:0]       item_qualification,
   input  wire logic [iprd_pkg::WORD_W-1:0]       item_guest_eax,
   input  wire logic [iprd_pkg::WORD_W-1:0]       item_read_value,
   output logic                                   res_valid,
   input  wire logic                              res_free,
   output iprd_pkg::result_type                   res_data,
   output logic                                   mem_we,
   output logic [AW-1:0]                          mem_waddr,
   output iprd_pkg::entry_type                    mem_wdata,
   output logic [AW-1:0]                          mem_raddr,
   input  wire iprd_pkg::entry_type               mem_rdata
);

   iprd_pkg::state_type  state_ff, state_in;
   iprd_pkg::status_type status_ff, status_in;
   iprd_pkg::func_type   func_ff, func_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [iprd_pkg::HID_W-1:0] hid_hit_ff, hid_hit_in;
   logic                 pt_hit_ff, pt_hit_in;

   // Latched item payload.
   logic [iprd_pkg::PORT_W-1:0] rs_ff, re_ff;
   logic                        rp_ff;
   logic [iprd_pkg::HID_W-1:0]  hid_ff;
   logic [iprd_pkg::WORD_W-1:0] qual_ff, eax_ff, rv_ff;

   logic                        accept;
   logic                        issue;
   logic                        cmp_hit;
   logic                        match_now;
   logic [iprd_pkg::PORT_W-1:0] cmp_lo, cmp_hi;
   logic [iprd_pkg::PORT_W-1:0] port;
   logic [iprd_pkg::SIZE_W-1:0] size;
   logic                        rd;
   logic                        str_rep;
   logic [iprd_pkg::WORD_W-1:0] mask;
   logic                        in_strrep;

   assign accept    = item_valid && !item_stall;
   assign in_strrep = |item_qualification[5:4];

   // Decoded fields of the latched qualification word.
   assign port    = qual_ff[31:16];
   assign size    = {1'b0, qual_ff[2:0]} + 4'd1;
   assign rd      = qual_ff[3];
   assign str_rep = |qual_ff[5:4];
   assign mask    = iprd_pkg::low_bytes_mask(size);

   // Shared comparator: an add tests overlap with [start, end], a decode
   // tests containment of the port, which is the same test with lo = hi.
   always_comb begin
      if (func_ff == iprd_pkg::FUNC_ADD) begin
         cmp_lo = rs_ff;
         cmp_hi = re_ff;
      end else begin
         cmp_lo = port;
         cmp_hi = port;
      end
   end
   assign cmp_hit   = (mem_rdata.last >= cmp_lo) && (mem_rdata.first <= cmp_hi);
   assign match_now = pend_ff && cmp_hit;
   assign issue     = (state_ff == iprd_pkg::S_SCAN) && !match_now && (idx_ff < count_ff);

   // Payload capture on an accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         rs_ff   <= item_range_start;
         re_ff   <= item_range_end;
         rp_ff   <= item_range_passthrough;
         hid_ff  <= item_handler_id;
         qual_ff <= item_qualification;
         eax_ff  <= item_guest_eax;
         rv_ff   <= item_read_value;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= iprd_pkg::S_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         status_ff <= iprd_pkg::ST_OK;
         func_ff   <= iprd_pkg::FUNC_NONE;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
         status_ff <= status_in;
         func_ff   <= func_in;
      end
   end

   always_ff @(posedge clock) begin
      hid_hit_ff <= hid_hit_in;
      pt_hit_ff  <= pt_hit_in;
   end

   // Next state, table writes and scan control.
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      func_in    = func_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pend_in    = 1'b0;
      hid_hit_in = hid_hit_ff;
      pt_hit_in  = pt_hit_ff;
      mem_we     = 1'b0;
      mem_waddr  = count_ff[AW-1:0];
      mem_wdata  = '{first: rs_ff, last: re_ff, passthrough: rp_ff, handler: hid_ff};
      mem_raddr  = idx_ff[AW-1:0];
      item_stall = (state_ff != iprd_pkg::S_IDLE);
      res_valid  = (state_ff == iprd_pkg::S_DONE);

      case (state_ff)
         iprd_pkg::S_IDLE: begin
            if (accept) begin
               func_in    = iprd_pkg::func_type'(item_func);
               idx_in     = '0;
               hid_hit_in = '0;
               pt_hit_in  = 1'b0;
               status_in  = iprd_pkg::ST_OK;
               case (iprd_pkg::func_type'(item_func))
                  iprd_pkg::FUNC_ADD: begin
                     state_in = iprd_pkg::S_SCAN;
                  end
                  iprd_pkg::FUNC_DECODE: begin
                     if (in_strrep) begin
                        status_in = iprd_pkg::ST_STRING;
                        state_in  = iprd_pkg::S_DONE;
                     end else begin
                        state_in = iprd_pkg::S_SCAN;
                     end
                  end
                  iprd_pkg::FUNC_COMPLETE: begin
                     state_in = iprd_pkg::S_DONE;
                  end
                  default: begin
                     state_in = iprd_pkg::S_IDLE;
                  end
               endcase
            end
         end

         iprd_pkg::S_SCAN: begin
            if (issue) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (match_now) begin
               // Matching entry found: an add is rejected, a decode hits.
               state_in   = iprd_pkg::S_DONE;
               hid_hit_in = mem_rdata.handler;
               pt_hit_in  = mem_rdata.passthrough;
               status_in  = (func_ff == iprd_pkg::FUNC_ADD) ? iprd_pkg::ST_OVERLAP
                                                            : iprd_pkg::ST_OK;
            end else if (idx_ff == count_ff) begin
               // Every valid entry has been compared without a match.
               state_in = iprd_pkg::S_DONE;
               if (func_ff == iprd_pkg::FUNC_ADD) begin
                  if (count_ff == CW'(MAX_RANGES)) begin
                     status_in = iprd_pkg::ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     count_in  = count_ff + CW'(1);
                     status_in = iprd_pkg::ST_OK;
                  end
               end else begin
                  status_in = iprd_pkg::ST_UNMAPPED;
               end
            end
         end

         iprd_pkg::S_DONE: begin
            if (res_free) begin
               state_in = iprd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = iprd_pkg::S_IDLE;
         end
      endcase
   end

   // Result beat built from the latched item and the scan outcome.
   always_comb begin
      res_data        = '0;
      res_data.status = status_ff;
      if (func_ff != iprd_pkg::FUNC_ADD) begin
         res_data.port_number = port;
         res_data.access_size = size;
         res_data.is_read     = rd;
      end
      if (func_ff == iprd_pkg::FUNC_COMPLETE) begin
         res_data.eax_valid  = 1'b1;
         res_data.new_eax    = (eax_ff & ~mask) | rv_ff;
         res_data.advance_ip = 1'b1;
      end else if (func_ff == iprd_pkg::FUNC_DECODE && !str_rep) begin
         if (status_ff == iprd_pkg::ST_OK) begin
            res_data.hit_handler     = hid_hit_ff;
            res_data.hit_passthrough = pt_hit_ff;
            res_data.out_value       = rd ? '0 : (eax_ff & mask);
         end else begin
            res_data.advance_ip = 1'b1;
            if (rd) begin
               res_data.eax_valid = 1'b1;
               res_data.new_eax   = eax_ff | mask;
            end
         end
      end
   end

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES))
      else $error("range count exceeds table depth");

   // A table write always grows the fill count by one.
   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("table write without count increment");

   // A matching entry, a rejected add or a decode hit, leaves the fill count untouched.
   a_overlap_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iprd_pkg::S_SCAN && match_now) |=> $stable(count_ff))
      else $error("table changed on matching entry");

endmodule

`default_nettype wire

// ===== sv/io_port_range_dispatch_core.sv =====
`default_nettype none

// I/O port range decoder. Add beats append a port range (with handler id and
// passthrough flag) to a table of MAX_RANGES entries, rejecting overlaps and
// flagging a full table; decode beats look an exit qualification's port up;
// complete-read beats merge a handler's read value into the accumulator. The
// block takes one beat at a time. An add or a lookup walks the table one
// entry per cycle through a single range comparator fed by the table's
// registered read port until it finds a match or reaches the fill count; a
// complete read or a string/rep decode skips the walk. A finished result sits
// in an output register, so the next request beat is taken while it waits.
// The table needs no clearing after reset: only entries below the fill count
// are ever compared.
module io_port_range_dispatch_core #(
   parameter int MAX_RANGES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_func,
   input  wire logic [iprd_pkg::PORT_W-1:0]       req_range_start,
   input  wire logic [iprd_pkg::PORT_W-1:0]       req_range_end,
   input  wire logic                              req_range_passthrough,
   input  wire logic [iprd_pkg::HID_W-1:0]        req_handler_id,
   input  wire logic [iprd_pkg::WORD_W-1:0]       req_qualification,
   input  wire logic [iprd_pkg::WORD_W-1:0]       req_guest_eax,
   input  wire logic [iprd_pkg::WORD_W-1:0]       req_read_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [iprd_pkg::STAT_W-1:0]            rsp_status,
   output logic [iprd_pkg::HID_W-1:0]             rsp_hit_handler,
   output logic                                   rsp_hit_passthrough,
   output logic [iprd_pkg::PORT_W-1:0]            rsp_port_number,
   output logic [iprd_pkg::SIZE_W-1:0]            rsp_access_size,
   output logic                                   rsp_is_read,
   output logic                                   rsp_eax_valid,
   output logic [iprd_pkg::WORD_W-1:0]            rsp_new_eax,
   output logic [iprd_pkg::WORD_W-1:0]            rsp_out_value,
   output logic                                   rsp_advance_ip
);

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   logic                 res_valid;
   logic                 res_free;
   iprd_pkg::result_type res_data;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;
   iprd_pkg::entry_type  mem_wdata;
   iprd_pkg::entry_type  mem_rdata;

   logic                 rsp_valid_ff, rsp_valid_in;
   iprd_pkg::result_type rsp_data_ff;

   iprd_ctrl #(
      .MAX_RANGES (MAX_RANGES),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .item_valid             (req_valid),
      .item_stall             (req_stall),
      .item_func              (req_func),
      .item_range_start       (req_range_start),
      .item_range_end         (req_range_end),
      .item_range_passthrough (req_range_passthrough),
      .item_handler_id        (req_handler_id),
      .item_qualification     (req_qualification),
      .item_guest_eax         (req_guest_eax),
      .item_read_value        (req_read_value),
      .res_valid              (res_valid),
      .res_free               (res_free),
      .res_data               (res_data),
      .mem_we                 (mem_we),
      .mem_waddr              (mem_waddr),
      .mem_wdata              (mem_wdata),
      .mem_raddr              (mem_raddr),
      .mem_rdata              (mem_rdata)
   );

   iprd_table #(
      .DEPTH (MAX_RANGES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Output register: free when empty or when its beat leaves this cycle.
   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_free) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_data_ff.status;
   assign rsp_hit_handler     = rsp_data_ff.hit_handler;
   assign rsp_hit_passthrough = rsp_data_ff.hit_passthrough;
   assign rsp_port_number     = rsp_data_ff.port_number;
   assign rsp_access_size     = rsp_data_ff.access_size;
   assign rsp_is_read         = rsp_data_ff.is_read;
   assign rsp_eax_valid       = rsp_data_ff.eax_valid;
   assign rsp_new_eax         = rsp_data_ff.new_eax;
   assign rsp_out_value       = rsp_data_ff.out_value;
   assign rsp_advance_ip      = rsp_data_ff.advance_ip;

endmodule

`default_nettype wire
